/* src/plru_pkg.sv */
// ----------------------------------------------------------------------------
// plru_pkg
// Types, sizes and codes shared by the partitioned LRU victim select block.
// ----------------------------------------------------------------------------
package plru_pkg;

	localparam int SETS     = 1024;
	localparam int WAYS     = 16;
	localparam int CPUS     = 4;

	localparam int STAMP_W  = 64;
	localparam int OWNER_W  = $clog2(CPUS + 1);
	localparam int ROW_AW   = $clog2(SETS);
	localparam int WAY_W    = $clog2(WAYS);

	localparam int OPC_W    = 2;
	localparam int CPU_W    = 2;
	localparam int SET_W    = 10;
	localparam int WIDX_W   = 4;
	localparam int VICTIM_W = 4;

	localparam logic [OWNER_W-1:0] NO_OWNER = OWNER_W'(CPUS);

	typedef enum logic [OPC_W-1:0] {
		OP_VICTIM = 2'd0,
		OP_FILL   = 2'd1,
		OP_UPDATE = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [OWNER_W-1:0] owner;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic             en;
		logic             restrict_own;
		logic [CPU_W-1:0] cpu;
	} scan_ctl_t;

	typedef struct packed {
		logic             last;
		logic [WAY_W-1:0] victim;
	} scan_sts_t;

	function automatic row_t clear_row();
		row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r[w].stamp = '0;
			r[w].owner = NO_OWNER;
		end
		return r;
	endfunction

endpackage

/* src/plru_if.sv */
// ----------------------------------------------------------------------------
// plru_if
// Request and response channels of the partitioned LRU victim select block.
// ----------------------------------------------------------------------------
interface plru_req_if;
	logic                          valid;
	logic                          ready;
	logic [plru_pkg::OPC_W-1:0]    opcode;
	logic [plru_pkg::CPU_W-1:0]    requester_cpu;
	logic [plru_pkg::SET_W-1:0]    set_index;
	logic [plru_pkg::WIDX_W-1:0]   way_index;
	logic                          is_write;
	logic                          hit;
	logic                          room_available;

	modport source (
		output valid, opcode, requester_cpu, set_index, way_index, is_write, hit,
		       room_available,
		input  ready
	);
	modport sink (
		input  valid, opcode, requester_cpu, set_index, way_index, is_write, hit,
		       room_available,
		output ready
	);
endinterface

interface plru_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [plru_pkg::VICTIM_W-1:0]   victim_way;

	modport source (output valid, victim_way, input ready);
	modport sink   (input valid, victim_way, output ready);
endinterface

/* src/partitioned_lru_victim_select.sv */
// ----------------------------------------------------------------------------
// partitioned_lru_victim_select
// Per-line use stamps and owners in one row-wide RAM, with a victim scan.
// ----------------------------------------------------------------------------
// After reset the row RAM is swept clear, one set per cycle, and no request
// is taken until it finishes. One request is handled at a time. Fills and
// access updates read the set row, then write it back with the new stamp. A
// victim request reads the row, then the scan walks one way per cycle with
// one stamp comparator for the whole set and one for the requester's lines,
// then the result is loaded into the response register once it is free.
// Requests that change nothing are taken straight from idle.
module partitioned_lru_victim_select (
	input  logic        clk,
	input  logic        arst_n,
	plru_req_if.sink    req,
	plru_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_data
);

	plru_pkg::state_t state_q, state_d;

	logic                            part_en_q;
	logic [plru_pkg::ROW_AW-1:0]     clr_q;
	logic [plru_pkg::STAMP_W-1:0]    use_counter_q;
	logic                            fill_q;
	logic [plru_pkg::CPU_W-1:0]      cpu_q;
	logic [plru_pkg::WAY_W-1:0]      way_q;
	logic                            restrict_q;
	logic                            rsp_valid_q;
	logic [plru_pkg::VICTIM_W-1:0]   victim_q;

	logic                            accept;
	logic                            way_ok;
	logic                            ram_we;
	logic [plru_pkg::ROW_AW-1:0]     ram_waddr;
	logic [plru_pkg::ROW_AW-1:0]     set_q;
	plru_pkg::row_t                  ram_wdata;
	logic                            ram_re;
	logic [$bits(plru_pkg::row_t)-1:0] ram_rdata;
	plru_pkg::row_t                  row;
	plru_pkg::row_t                  mod_row;
	plru_pkg::scan_ctl_t             scan_ctl;
	plru_pkg::scan_sts_t             scan_sts;
	logic                            rsp_load;

	plru_ram #(
		.WIDTH ($bits(plru_pkg::row_t)),
		.DEPTH (plru_pkg::SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req.set_index[plru_pkg::ROW_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign row = plru_pkg::row_t'(ram_rdata);

	plru_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.row    (row),
		.sts    (scan_sts)
	);

	assign accept   = req.valid && req.ready;
	assign way_ok   = ({1'b0, req.way_index} < (plru_pkg::WIDX_W + 1)'(plru_pkg::WAYS));
	assign rsp_load = (state_q == plru_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mod_row = row;
		mod_row[way_q].stamp = use_counter_q;
		if (fill_q) begin
			mod_row[way_q].owner = plru_pkg::OWNER_W'(cpu_q);
		end
	end

	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		ram_re       = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = set_q;
		ram_wdata    = mod_row;
		scan_ctl.en  = 1'b0;
		scan_ctl.restrict_own = restrict_q;
		scan_ctl.cpu = cpu_q;
		case (state_q)
			plru_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = plru_pkg::clear_row();
				if (clr_q == plru_pkg::ROW_AW'(plru_pkg::SETS - 1)) begin
					state_d = plru_pkg::ST_IDLE;
				end
			end
			plru_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.opcode)
						plru_pkg::OP_VICTIM: begin
							ram_re  = 1'b1;
							state_d = plru_pkg::ST_SCAN;
						end
						plru_pkg::OP_FILL: begin
							if (way_ok) begin
								ram_re  = 1'b1;
								state_d = plru_pkg::ST_WRITE;
							end
						end
						plru_pkg::OP_UPDATE: begin
							if (way_ok && req.hit && !req.is_write) begin
								ram_re  = 1'b1;
								state_d = plru_pkg::ST_WRITE;
							end
						end
						default: ;
					endcase
				end
			end
			plru_pkg::ST_SCAN: begin
				scan_ctl.en = 1'b1;
				if (scan_sts.last) begin
					state_d = plru_pkg::ST_DONE;
				end
			end
			plru_pkg::ST_DONE: begin
				if (rsp_load) begin
					state_d = plru_pkg::ST_IDLE;
				end
			end
			plru_pkg::ST_WRITE: begin
				ram_we  = 1'b1;
				state_d = plru_pkg::ST_IDLE;
			end
			default: state_d = plru_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= plru_pkg::ST_CLEAR;
			clr_q         <= '0;
			use_counter_q <= '0;
			part_en_q     <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plru_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == plru_pkg::ST_WRITE) begin
				use_counter_q <= use_counter_q + 1'b1;
			end
			if (cfg_we) begin
				part_en_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q     <= (req.opcode == plru_pkg::OP_FILL);
			cpu_q      <= req.requester_cpu;
			way_q      <= req.way_index[plru_pkg::WAY_W-1:0];
			set_q      <= req.set_index[plru_pkg::ROW_AW-1:0];
			restrict_q <= part_en_q && !req.room_available;
		end
		if (rsp_load) begin
			victim_q <= plru_pkg::VICTIM_W'(scan_sts.victim);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.victim_way = victim_q;

	a_counter_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != plru_pkg::ST_WRITE) |=> (use_counter_q == $past(use_counter_q)))
		else $error("use counter moved outside a write-back");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == plru_pkg::ST_DONE))
		else $error("response raised without a finished scan");

	a_scan_last_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.last |-> ((state_q == plru_pkg::ST_SCAN) && !ram_we))
		else $error("scan end outside scan state");

endmodule

/* src/plru_ram.sv */
// ----------------------------------------------------------------------------
// plru_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/plru_scan.sv */
// ----------------------------------------------------------------------------
// plru_scan
// Walks one set row a way per cycle while enabled, tracking the oldest way
// overall and the oldest way owned by the requester.
// ----------------------------------------------------------------------------
module plru_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plru_pkg::scan_ctl_t   ctl,
	input  plru_pkg::row_t        row,
	output plru_pkg::scan_sts_t   sts
);

	logic [plru_pkg::WAY_W-1:0]   way_q;
	logic [plru_pkg::STAMP_W-1:0] all_stamp_q;
	logic [plru_pkg::WAY_W-1:0]   all_way_q;
	logic [plru_pkg::STAMP_W-1:0] own_stamp_q;
	logic [plru_pkg::WAY_W-1:0]   own_way_q;
	logic                         own_found_q;

	plru_pkg::line_t cur;
	logic            first;
	logic            last;
	logic            take_all;
	logic            take_own;
	logic            is_own;

	always_comb begin
		cur      = row[way_q];
		first    = (way_q == '0);
		last     = (way_q == plru_pkg::WAY_W'(plru_pkg::WAYS - 1));
		is_own   = (cur.owner == plru_pkg::OWNER_W'(ctl.cpu));
		take_all = first || (cur.stamp < all_stamp_q);
		take_own = is_own && (first || !own_found_q || (cur.stamp < own_stamp_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q       <= '0;
			own_found_q <= 1'b0;
		end else if (ctl.en) begin
			way_q       <= last ? '0 : way_q + 1'b1;
			own_found_q <= (first ? 1'b0 : own_found_q) | is_own;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && take_all) begin
			all_stamp_q <= cur.stamp;
			all_way_q   <= way_q;
		end
		if (ctl.en && take_own) begin
			own_stamp_q <= cur.stamp;
			own_way_q   <= way_q;
		end
	end

	assign sts.last   = ctl.en && last;
	assign sts.victim = (ctl.restrict_own && own_found_q) ? own_way_q : all_way_q;

endmodule

/* sim/partitioned_lru_victim_select_tb.sv */
// ----------------------------------------------------------------------------
// partitioned_lru_victim_select_tb
// Self-checking bench for the partitioned LRU victim select block.
// A line-level mirror of stamps, owners and the use counter predicts every
// victim choice. Directed requests cover fresh sets, the fill and update
// corner cases and ownership-restricted choice. Random traffic on a few busy
// sets then runs with partitioning on and off, under random request and
// response stalls.
// ----------------------------------------------------------------------------
module partitioned_lru_victim_select_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [plru_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = plru_pkg::WAYS + 4;

	typedef struct packed {
		logic [plru_pkg::OPC_W-1:0]  opcode;
		logic [plru_pkg::CPU_W-1:0]  cpu;
		logic [plru_pkg::SET_W-1:0]  set_idx;
		logic [plru_pkg::WIDX_W-1:0] way;
		logic                        is_write;
		logic                        hit;
		logic                        room;
	} request_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	plru_req_if req_if();
	plru_rsp_if rsp_if();

	partitioned_lru_victim_select u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	logic [plru_pkg::STAMP_W-1:0]  line_stamp [plru_pkg::SETS*plru_pkg::WAYS];
	logic [plru_pkg::OWNER_W-1:0]  line_owner [plru_pkg::SETS*plru_pkg::WAYS];
	logic [plru_pkg::STAMP_W-1:0]  use_count;
	logic                          partition_on;
	logic [plru_pkg::VICTIM_W-1:0] victim_q [$];

	logic req_calm;
	logic rsp_calm;
	int   errors;
	int   quiet_cycles;
	int   n_victims;
	int   n_fills;
	int   n_updates;
	int   n_ignored;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [plru_pkg::WAY_W-1:0] pick_victim(
			input logic [plru_pkg::SET_W-1:0] s,
			input logic [plru_pkg::CPU_W-1:0] cpu, input logic room);
		int base;
		logic own_only;
		logic found;
		logic [plru_pkg::WAY_W-1:0] best;
		logic [plru_pkg::STAMP_W-1:0] best_stamp;
		base = (int'(s) % plru_pkg::SETS) * plru_pkg::WAYS;
		own_only = partition_on && !room;
		found = 1'b0;
		best = '0;
		best_stamp = '0;
		for (int w = 0; w < plru_pkg::WAYS; w++) begin
			if ((!own_only || line_owner[base + w] == plru_pkg::OWNER_W'(cpu)) &&
			    (!found || line_stamp[base + w] < best_stamp)) begin
				best = plru_pkg::WAY_W'(w);
				best_stamp = line_stamp[base + w];
				found = 1'b1;
			end
		end
		// requester owns nothing here: fall back to the whole set
		if (!found) begin
			for (int w = 0; w < plru_pkg::WAYS; w++) begin
				if (!found || line_stamp[base + w] < best_stamp) begin
					best = plru_pkg::WAY_W'(w);
					best_stamp = line_stamp[base + w];
					found = 1'b1;
				end
			end
		end
		return best;
	endfunction

	task automatic stamp_line(input logic [plru_pkg::SET_W-1:0] s,
			input logic [plru_pkg::WIDX_W-1:0] w);
		int idx;
		idx = (int'(s) % plru_pkg::SETS) * plru_pkg::WAYS + int'(w);
		line_stamp[idx] = use_count;
		use_count = use_count + 1;
	endtask

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			if (victim_q.size() == 0) begin
				$display("%0t: victim_way expected none, actual %0d", $time, rsp_if.victim_way);
				errors++;
			end else if (rsp_if.victim_way !== victim_q[0]) begin
				$display("%0t: victim_way expected %0d, actual %0d", $time, victim_q[0],
					rsp_if.victim_way);
				errors++;
				void'(victim_q.pop_front());
			end else begin
				void'(victim_q.pop_front());
			end
		end
		if (req_if.valid && req_if.ready) begin
			case (req_if.opcode)
				plru_pkg::OP_VICTIM: begin
					victim_q = {victim_q, pick_victim(req_if.set_index,
						req_if.requester_cpu, req_if.room_available)};
					n_victims++;
				end
				plru_pkg::OP_FILL: begin
					stamp_line(req_if.set_index, req_if.way_index);
					line_owner[(int'(req_if.set_index) % plru_pkg::SETS) * plru_pkg::WAYS +
						int'(req_if.way_index)] = plru_pkg::OWNER_W'(req_if.requester_cpu);
					n_fills++;
				end
				plru_pkg::OP_UPDATE: begin
					if (req_if.hit && !req_if.is_write)
						stamp_line(req_if.set_index, req_if.way_index);
					n_updates++;
				end
				default: begin
					n_ignored++;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
			$display("partitioned_lru_victim_select test failed");
			$finish;
		end
	end

	// response side
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = rsp_calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
		end
	end

	function automatic request_t make_req(input logic [plru_pkg::OPC_W-1:0] op,
			input logic [plru_pkg::CPU_W-1:0] cpu, input logic [plru_pkg::SET_W-1:0] s,
			input logic [plru_pkg::WIDX_W-1:0] w, input logic wr, input logic h,
			input logic rm);
		request_t r;
		r.opcode = op;
		r.cpu = cpu;
		r.set_idx = s;
		r.way = w;
		r.is_write = wr;
		r.hit = h;
		r.room = rm;
		return r;
	endfunction

	task automatic issue(input request_t r);
		int gap;
		gap = req_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= r.opcode;
		req_if.requester_cpu <= r.cpu;
		req_if.set_index <= r.set_idx;
		req_if.way_index <= r.way;
		req_if.is_write <= r.is_write;
		req_if.hit <= r.hit;
		req_if.room_available <= r.room;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (victim_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_partition(input logic v);
		wait_idle();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		partition_on = v;
	endtask

	task automatic test_plain_lru();
		set_partition(1'b0);
		issue(make_req(plru_pkg::OP_VICTIM, 0, 0, 0, 0, 0, 1));
		issue(make_req(plru_pkg::OP_VICTIM, 3, 1023, 15, 1, 1, 0));
		// fill ignores hit and write
		issue(make_req(plru_pkg::OP_FILL, 3, 1023, 15, 1, 0, 0));
		issue(make_req(plru_pkg::OP_FILL, 2, 1023, 0, 0, 1, 1));
		issue(make_req(plru_pkg::OP_UPDATE, 1, 1023, 15, 0, 0, 1));
		issue(make_req(plru_pkg::OP_UPDATE, 1, 1023, 15, 1, 1, 1));
		issue(make_req(OP_UNUSED, 0, 1023, 1, 0, 1, 0));
		issue(make_req(plru_pkg::OP_UPDATE, 0, 1023, 0, 0, 1, 0));
		issue(make_req(plru_pkg::OP_VICTIM, 2, 1023, 0, 0, 0, 0));
	endtask

	task automatic test_partitioned();
		set_partition(1'b1);
		issue(make_req(plru_pkg::OP_FILL, 1, 512, 3, 0, 0, 0));
		issue(make_req(plru_pkg::OP_FILL, 1, 512, 7, 0, 1, 0));
		issue(make_req(plru_pkg::OP_FILL, 0, 512, 9, 0, 1, 1));
		issue(make_req(plru_pkg::OP_VICTIM, 1, 512, 0, 0, 0, 0));
		issue(make_req(plru_pkg::OP_UPDATE, 1, 512, 3, 0, 1, 0));
		issue(make_req(plru_pkg::OP_VICTIM, 1, 512, 0, 0, 0, 0));
		issue(make_req(plru_pkg::OP_VICTIM, 2, 512, 0, 0, 0, 0));
		issue(make_req(plru_pkg::OP_VICTIM, 1, 512, 0, 0, 0, 1));
		issue(make_req(plru_pkg::OP_VICTIM, 0, 512, 15, 1, 1, 0));
	endtask

	task automatic test_random_traffic(input int count, input logic pe);
		logic [plru_pkg::SET_W-1:0] busy_set [4];
		request_t r;
		int pick;
		set_partition(pe);
		busy_set[0] = '0;
		busy_set[1] = plru_pkg::SET_W'(plru_pkg::SETS - 1);
		busy_set[2] = plru_pkg::SET_W'($urandom_range(0, plru_pkg::SETS - 1));
		busy_set[3] = plru_pkg::SET_W'($urandom_range(0, plru_pkg::SETS - 1));
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				req_calm = ($urandom_range(0, 3) == 0);
				rsp_calm = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 30)
				r.opcode = plru_pkg::OP_VICTIM;
			else if (pick < 65)
				r.opcode = plru_pkg::OP_FILL;
			else if (pick < 95)
				r.opcode = plru_pkg::OP_UPDATE;
			else
				r.opcode = OP_UNUSED;
			r.cpu = plru_pkg::CPU_W'($urandom_range(0, plru_pkg::CPUS - 1));
			if ($urandom_range(0, 9) == 0)
				r.set_idx = plru_pkg::SET_W'($urandom_range(0, plru_pkg::SETS - 1));
			else
				r.set_idx = busy_set[$urandom_range(0, 3)];
			r.way = plru_pkg::WIDX_W'($urandom_range(0, plru_pkg::WAYS - 1));
			r.is_write = ($urandom_range(0, 3) == 0);
			r.hit = ($urandom_range(0, 3) != 0);
			r.room = 1'($urandom_range(0, 1));
			issue(r);
		end
		req_calm = 1'b0;
		rsp_calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.opcode <= '0;
		req_if.requester_cpu <= '0;
		req_if.set_index <= '0;
		req_if.way_index <= '0;
		req_if.is_write <= 1'b0;
		req_if.hit <= 1'b0;
		req_if.room_available <= 1'b0;
		for (int i = 0; i < plru_pkg::SETS * plru_pkg::WAYS; i++) begin
			line_stamp[i] = '0;
			line_owner[i] = plru_pkg::NO_OWNER;
		end
		use_count = '0;
		partition_on = 1'b0;
		req_calm = 1'b0;
		rsp_calm = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		n_victims = 0;
		n_fills = 0;
		n_updates = 0;
		n_ignored = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_plain_lru();
		test_partitioned();
		test_random_traffic(235, 1'b1);
		test_random_traffic(235, 1'b0);
		test_random_traffic(235, 1'b1);
		test_random_traffic(227, 1'b0);
		wait_idle();

		while (victim_q.size() != 0) begin
			$display("%0t: victim_way expected %0d, actual none", $time, victim_q[0]);
			void'(victim_q.pop_front());
			errors++;
		end
		$display("Ran %0d victim choices, %0d fills, %0d access updates, %0d unused opcodes",
			n_victims, n_fills, n_updates, n_ignored);
		$display("with partitioning off and on, under random and zero stalls; %0d mismatches",
			errors);
		if (errors == 0)
			$display("partitioned_lru_victim_select test passed");
		else
			$display("partitioned_lru_victim_select test failed");
		$finish;
	end

endmodule
